@@ design/mfap_pkg.sv @@
// mfap_pkg: shared constants, opcodes and helpers for the max-flow unit.
// No dependencies.
package mfap_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int MADDR_W   = 2 * NODE_W;
  localparam int FLOW_W    = 32;
  localparam int CAP_W     = 16;
  localparam int CFG_W     = 7;
  localparam int CIDX_W    = 2;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_COMPUTE  = 1'b1;

  localparam logic [CIDX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SOURCE_VERTEX = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SINK_VERTEX   = 2'd2;

  function automatic logic [FLOW_W-1:0] sat_add(input logic [FLOW_W-1:0] a,
                                                input logic [FLOW_W-1:0] b);
    logic [FLOW_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FLOW_W] ? {FLOW_W{1'b1}} : s[FLOW_W-1:0];
  endfunction

endpackage

@@ design/mfap_ram.sv @@
// mfap_ram: single-port synchronous RAM with registered read.
// No dependencies.
module mfap_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/max_flow_augmenting_path_unit.sv @@
// Max-flow unit: residual matrix memory, BFS queue and parent memories, sequencer.
// Depends on mfap_pkg and mfap_ram.
//
// An add-edge word reads then writes back one matrix entry.
// A compute word runs breadth-first searches over the residual matrix, one
// matrix entry per cycle through its single port: each search pops each queued
// vertex, reads it from the queue and scans its row, and each path found is
// traced for its bottleneck and augmented. The result is then emitted and all
// MAX_NODES*MAX_NODES (4096) matrix entries are cleared, one entry a cycle;
// the same clearing pass runs after reset. Input is stalled throughout.
module max_flow_augmenting_path_unit
  import mfap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CIDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [NODE_W-1:0]    from_vertex_i,
  input  logic [NODE_W-1:0]    to_vertex_i,
  input  logic [CAP_W-1:0]     edge_capacity_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FLOW_W-1:0]    total_flow_o
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_ADD_WR = 5'd1;
  localparam logic [4:0] ST_INIT   = 5'd2;
  localparam logic [4:0] ST_POP    = 5'd3;
  localparam logic [4:0] ST_POP_W  = 5'd4;
  localparam logic [4:0] ST_SCAN   = 5'd5;
  localparam logic [4:0] ST_TR1    = 5'd6;
  localparam logic [4:0] ST_TR2    = 5'd7;
  localparam logic [4:0] ST_TR3    = 5'd8;
  localparam logic [4:0] ST_AU1    = 5'd9;
  localparam logic [4:0] ST_AU2    = 5'd10;
  localparam logic [4:0] ST_AU3    = 5'd11;
  localparam logic [4:0] ST_AU4    = 5'd12;
  localparam logic [4:0] ST_AU5    = 5'd13;
  localparam logic [4:0] ST_EMIT   = 5'd14;
  localparam logic [4:0] ST_CLR    = 5'd15;

  logic [4:0]           state_q, state_d;
  logic [MADDR_W-1:0]   cnt_q, cnt_d;
  logic [CFG_W-1:0]     vc_q;
  logic [NODE_W-1:0]    src_q, dst_q;
  logic [NODE_W-1:0]    u_q, u_d, p_q, p_d;
  logic [CNT_W-1:0]     v_q, v_d, head_q, head_d, tail_q, tail_d;
  logic [MAX_NODES-1:0] vis_q, vis_d;
  logic                 found_q, found_d;
  logic [FLOW_W-1:0]    bn_q, bn_d, flow_q, flow_d, total_q, total_d;
  logic [CAP_W-1:0]     cap_q, cap_d;
  logic [MADDR_W-1:0]   ea_q, ea_d;
  logic                 outv_q, outv_d;

  logic                 m_we;
  logic [MADDR_W-1:0]   m_addr;
  logic [FLOW_W-1:0]    m_wdata, m_rdata;
  logic                 p_we, q_we;
  logic [NODE_W-1:0]    p_addr, p_wdata, p_rdata, q_addr, q_wdata, q_rdata;

  logic                 in_acc;
  logic [CNT_W-1:0]     n_w, v_nx;
  logic                 take;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = outv_q;
  assign total_flow_o = total_q;
  assign n_w  = (vc_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(vc_q);
  assign v_nx = v_q + 1'b1;
  assign take = !vis_q[v_q[NODE_W-1:0]] && (m_rdata != '0) &&
                (tail_q < CNT_W'(MAX_NODES));

  mfap_ram #(.ADDR_W(MADDR_W), .DATA_W(FLOW_W)) u_matrix (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wdata), .rdata_o(m_rdata)
  );
  mfap_ram #(.ADDR_W(NODE_W), .DATA_W(NODE_W)) u_parent (
    .clk_i, .we_i(p_we), .addr_i(p_addr), .wdata_i(p_wdata), .rdata_o(p_rdata)
  );
  mfap_ram #(.ADDR_W(NODE_W), .DATA_W(NODE_W)) u_queue (
    .clk_i, .we_i(q_we), .addr_i(q_addr), .wdata_i(q_wdata), .rdata_o(q_rdata)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    u_d     = u_q;
    p_d     = p_q;
    v_d     = v_q;
    head_d  = head_q;
    tail_d  = tail_q;
    vis_d   = vis_q;
    found_d = found_q;
    bn_d    = bn_q;
    flow_d  = flow_q;
    total_d = total_q;
    cap_d   = cap_q;
    ea_d    = ea_q;
    outv_d  = outv_q && out_stall_i;
    m_we    = 1'b0;
    m_addr  = '0;
    m_wdata = '0;
    p_we    = 1'b0;
    p_addr  = '0;
    p_wdata = '0;
    q_we    = 1'b0;
    q_addr  = '0;
    q_wdata = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OP_ADD_EDGE) begin
            m_addr  = {from_vertex_i, to_vertex_i};
            ea_d    = {from_vertex_i, to_vertex_i};
            cap_d   = edge_capacity_i;
            state_d = ST_ADD_WR;
          end else begin
            flow_d = '0;
            if (src_q == dst_q || CNT_W'(src_q) >= n_w || CNT_W'(dst_q) >= n_w) begin
              state_d = ST_EMIT;
            end else begin
              state_d = ST_INIT;
            end
          end
        end
      end
      ST_ADD_WR: begin
        m_we    = 1'b1;
        m_addr  = ea_q;
        m_wdata = sat_add(m_rdata, FLOW_W'(cap_q));
        state_d = ST_IDLE;
      end
      ST_INIT: begin
        vis_d        = '0;
        vis_d[src_q] = 1'b1;
        found_d      = 1'b0;
        p_we         = 1'b1;
        p_addr       = src_q;
        p_wdata      = src_q;
        q_we         = 1'b1;
        q_addr       = '0;
        q_wdata      = src_q;
        head_d       = '0;
        tail_d       = CNT_W'(1);
        state_d      = ST_POP;
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          if (found_q) begin
            v_d     = CNT_W'(dst_q);
            bn_d    = '1;
            state_d = ST_TR1;
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          q_addr  = head_q[NODE_W-1:0];
          head_d  = head_q + 1'b1;
          state_d = ST_POP_W;
        end
      end
      ST_POP_W: begin
        u_d     = q_rdata;
        v_d     = '0;
        m_addr  = {q_rdata, {NODE_W{1'b0}}};
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        m_addr = {u_q, v_nx[NODE_W-1:0]};
        if (take) begin
          q_we    = 1'b1;
          q_addr  = tail_q[NODE_W-1:0];
          q_wdata = v_q[NODE_W-1:0];
          p_we    = 1'b1;
          p_addr  = v_q[NODE_W-1:0];
          p_wdata = u_q;
          vis_d[v_q[NODE_W-1:0]] = 1'b1;
          tail_d  = tail_q + 1'b1;
          if (v_q[NODE_W-1:0] == dst_q) begin
            found_d = 1'b1;
          end
        end
        v_d = v_nx;
        if (v_nx == n_w) begin
          state_d = ST_POP;
        end
      end
      ST_TR1: begin
        if (v_q[NODE_W-1:0] == src_q) begin
          v_d     = CNT_W'(dst_q);
          state_d = ST_AU1;
        end else begin
          p_addr  = v_q[NODE_W-1:0];
          state_d = ST_TR2;
        end
      end
      ST_TR2: begin
        p_d     = p_rdata;
        m_addr  = {p_rdata, v_q[NODE_W-1:0]};
        state_d = ST_TR3;
      end
      ST_TR3: begin
        if (m_rdata < bn_q) begin
          bn_d = m_rdata;
        end
        v_d     = CNT_W'(p_q);
        state_d = ST_TR1;
      end
      ST_AU1: begin
        if (v_q[NODE_W-1:0] == src_q) begin
          flow_d  = sat_add(flow_q, bn_q);
          state_d = ST_INIT;
        end else begin
          p_addr  = v_q[NODE_W-1:0];
          state_d = ST_AU2;
        end
      end
      ST_AU2: begin
        p_d     = p_rdata;
        m_addr  = {p_rdata, v_q[NODE_W-1:0]};
        state_d = ST_AU3;
      end
      ST_AU3: begin
        m_we    = 1'b1;
        m_addr  = {p_q, v_q[NODE_W-1:0]};
        m_wdata = m_rdata - bn_q;
        state_d = ST_AU4;
      end
      ST_AU4: begin
        m_addr  = {v_q[NODE_W-1:0], p_q};
        state_d = ST_AU5;
      end
      ST_AU5: begin
        m_we    = 1'b1;
        m_addr  = {v_q[NODE_W-1:0], p_q};
        m_wdata = sat_add(m_rdata, bn_q);
        v_d     = CNT_W'(p_q);
        state_d = ST_AU1;
      end
      ST_EMIT: begin
        if (!outv_q || !out_stall_i) begin
          outv_d  = 1'b1;
          total_d = flow_q;
          cnt_d   = '0;
          state_d = ST_CLR;
        end
      end
      ST_CLR: begin
        m_we   = 1'b1;
        m_addr = cnt_q;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      cnt_q   <= '0;
      vc_q    <= CFG_W'(64);
      src_q   <= '0;
      dst_q   <= NODE_W'(63);
      head_q  <= '0;
      tail_q  <= '0;
      vis_q   <= '0;
      found_q <= 1'b0;
      flow_q  <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      vis_q   <= vis_d;
      found_q <= found_d;
      flow_q  <= flow_d;
      outv_q  <= outv_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_VERTEX_COUNT:  vc_q  <= cfg_data_i;
          REG_SOURCE_VERTEX: src_q <= cfg_data_i[NODE_W-1:0];
          REG_SINK_VERTEX:   dst_q <= cfg_data_i[NODE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    p_q     <= p_d;
    v_q     <= v_d;
    bn_q    <= bn_d;
    total_q <= total_d;
    cap_q   <= cap_d;
    ea_q    <= ea_d;
  end

`ifndef NO_ASSERTIONS
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= CNT_W'(MAX_NODES))
    else $error("queue tail beyond node count");

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_POP) |-> head_q <= tail_q)
    else $error("queue head passed tail");

  a_add_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_ADD_EDGE) |=> state_q == ST_ADD_WR)
    else $error("edge word not written back");

  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!outv_q || !out_stall_i)) |=> (outv_q && state_q == ST_CLR))
    else $error("result not loaded before clearing");
`endif

endmodule
